[rtl/imu_motion_event_detector_unit_defines.svh]
// imu motion event detector: assertion macros for the checker files
// depends on nothing; the including module must have clk_i and rst_ni
`ifndef IMU_MOTION_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define IMU_MOTION_EVENT_DETECTOR_UNIT_DEFINES_SVH

// concurrent check on the block clock, masked while in reset
`define IMED_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same check with a generic message
`define IMED_ASSERT(lbl, prop) `IMED_ASSERT_MSG(lbl, prop, "imed check failed")

`endif

[rtl/imed_pkg.sv]
// imu motion event detector: shared widths, codes and beat types
// depends on nothing; used by every module of the block
package imed_pkg;

  // fixed point layout of the baseline
  localparam int BASE_FRAC_BITS = 16;
  localparam int SMP_W          = 16;
  localparam int FIX_W          = SMP_W + BASE_FRAC_BITS;
  localparam int DIF_W          = FIX_W + 1;

  // filter coefficient, alpha 0.02 in q16
  localparam int ALPHA_Q16      = 1311;
  localparam int ALPHA_W        = 12;
  localparam int ALPHA_SHIFT    = 16;
  localparam int PROD_W         = DIF_W + ALPHA_W;

  // deviation keeps a few fractional bits
  localparam int DEV_FRAC_BITS  = 8;
  localparam int DEV_SHIFT      = BASE_FRAC_BITS - DEV_FRAC_BITS;
  localparam int DEV_W          = DIF_W + 1 - DEV_SHIFT;

  // squares and sums
  localparam int SQ_W           = 2 * SMP_W - 1;
  localparam int SUM_W          = SQ_W + 2;
  localparam int DSQ_W          = 2 * DEV_W;
  localparam int DSUM_W         = DSQ_W + 2;
  localparam int LVL_W          = 16;
  localparam int LSQ_W          = 2 * LVL_W;
  localparam int MREF_W         = LSQ_W + 2 * DEV_FRAC_BITS;
  localparam int TIME_W         = 32;

  localparam int NUM_LANES      = 3;
  localparam int NUM_EV         = 4;

  // event bit positions
  localparam int EV_IMPACT      = 0;
  localparam int EV_MOVE        = 1;
  localparam int EV_ROTATE      = 2;
  localparam int EV_FALL        = 3;

  // configuration register indexes
  localparam int CFG_IDX_W      = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 3'd5;

  // item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_z;
    logic [TIME_W-1:0]       time_ms;
  } imed_in_t;

  typedef struct packed {
    logic [NUM_EV-1:0] event_bits;
    logic              motion_flag;
  } imed_out_t;

  typedef struct packed {
    logic [LVL_W-1:0] impact_level;
    logic [LVL_W-1:0] move_level;
    logic [LVL_W-1:0] rotate_level;
    logic [LVL_W-1:0] freefall_level;
    logic [LVL_W-1:0] freefall_hold_ms;
    logic [LVL_W-1:0] warmup_ms;
  } imed_cfg_t;

  // per-cycle enables from the sequencer to lanes and merge
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic dev;
    logic sq;
    logic merge;
  } imed_step_t;

endpackage

[rtl/imed_lane.sv]
// imu motion event detector: one axis lane (baseline filter, deviation, squares)
// depends on imed_pkg
module imed_lane import imed_pkg::*; (
  input  logic                    clk_i,
  input  imed_step_t              step_i,
  input  logic                    seeded_i,
  input  logic signed [SMP_W-1:0] accel_i,
  input  logic signed [SMP_W-1:0] gyro_i,
  output logic [SQ_W-1:0]         acc_sq_o,
  output logic [SQ_W-1:0]         gyr_sq_o,
  output logic [DSQ_W-1:0]        dev_sq_o
);

  localparam logic signed [ALPHA_W-1:0] ALPHA_C   = ALPHA_W'(ALPHA_Q16);
  localparam logic [PROD_W-1:0]         ALPHA_RND = PROD_W'(1) << (ALPHA_SHIFT - 1);
  localparam logic [DIF_W:0]            DEV_RND   = (DIF_W + 1)'((1 << DEV_SHIFT) >> 1);

  logic signed [FIX_W-1:0]   base_q;
  logic signed [DIF_W-1:0]   dif_q;
  logic signed [DIF_W-1:0]   adj_q;
  logic signed [DEV_W-1:0]   dev_q;
  logic [SQ_W-1:0]           acc_sq_q;
  logic [SQ_W-1:0]           gyr_sq_q;
  logic [DSQ_W-1:0]          dev_sq_q;

  logic signed [FIX_W-1:0]   fixed;
  logic signed [DIF_W-1:0]   dif_d;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [FIX_W-1:0]   base_upd;
  logic signed [DIF_W:0]     dev_rnd;
  logic signed [DIF_W:0]     dev_sh;
  logic signed [2*SMP_W-1:0] acc_p;
  logic signed [2*SMP_W-1:0] gyr_p;
  logic signed [DSQ_W-1:0]   dev_p;

  // sample scaled to baseline format
  assign fixed = {accel_i, {BASE_FRAC_BITS{1'b0}}};

  // distance to baseline, zero on the seeding sample
  assign dif_d = seeded_i ? ({fixed[FIX_W-1], fixed} - {base_q[FIX_W-1], base_q}) : '0;

  // alpha step, rounded half up
  assign prod     = dif_q * ALPHA_C;
  assign prod_rnd = prod + $signed(ALPHA_RND);
  assign prod_sh  = prod_rnd >>> ALPHA_SHIFT;

  assign base_upd = base_q + adj_q[FIX_W-1:0];

  // deviation after the update, rounded to the deviation format
  assign dev_rnd = {{2{fixed[FIX_W-1]}}, fixed} - {{2{base_q[FIX_W-1]}}, base_q}
                   + $signed(DEV_RND);
  assign dev_sh  = dev_rnd >>> DEV_SHIFT;

  // raw squares
  assign acc_p = accel_i * accel_i;
  assign gyr_p = gyro_i * gyro_i;
  assign dev_p = dev_q * dev_q;

  // lane registers, each step one operation deep
  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      if (!seeded_i) begin
        base_q <= fixed;
      end
      dif_q    <= dif_d;
      acc_sq_q <= acc_p[SQ_W-1:0];
      gyr_sq_q <= gyr_p[SQ_W-1:0];
    end
    if (step_i.mul) begin
      adj_q <= prod_sh[DIF_W-1:0];
    end
    if (step_i.upd) begin
      base_q <= base_upd;
    end
    if (step_i.dev) begin
      dev_q <= dev_sh[DEV_W-1:0];
    end
    if (step_i.sq) begin
      dev_sq_q <= dev_p;
    end
  end

  assign acc_sq_o = acc_sq_q;
  assign gyr_sq_o = gyr_sq_q;
  assign dev_sq_o = dev_sq_q;

endmodule

[rtl/imed_merge.sv]
// imu motion event detector: merge of lane results, warm-up, free fall, sticky events
// depends on imed_pkg
module imed_merge import imed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imed_step_t        step_i,
  input  logic              clear_i,
  input  logic [TIME_W-1:0] now_i,
  input  imed_cfg_t         cfg_i,
  input  logic [SQ_W-1:0]   acc_sq_i [NUM_LANES],
  input  logic [SQ_W-1:0]   gyr_sq_i [NUM_LANES],
  input  logic [DSQ_W-1:0]  dev_sq_i [NUM_LANES],
  output logic              seeded_o,
  output imed_out_t         res_o
);

  logic              seeded_q;
  logic [TIME_W-1:0] start_q;
  logic              warm_q;
  logic [SUM_W-1:0]  total_q;
  logic [SUM_W-1:0]  gyro_q;
  logic [LSQ_W-1:0]  impact_sq_q;
  logic [LSQ_W-1:0]  move_sq_q;
  logic [LSQ_W-1:0]  rotate_sq_q;
  logic [LSQ_W-1:0]  ff_sq_q;
  logic              fall_valid_q;
  logic [TIME_W-1:0] fall_since_q;
  logic [NUM_EV-1:0] events_q;
  logic              active_q;

  logic [SUM_W-1:0]  total_sum;
  logic [SUM_W-1:0]  gyro_sum;
  logic [DSUM_W-1:0] dev_sum;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] fall_age;
  logic [MREF_W-1:0] move_ref_sq;
  logic [NUM_EV-1:0] hit;
  logic              fall_valid_d;
  logic [TIME_W-1:0] fall_since_d;
  logic [NUM_EV-1:0] events_d;
  logic              active_d;

  // lane sums
  always_comb begin
    total_sum = '0;
    gyro_sum  = '0;
    dev_sum   = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      total_sum = total_sum + SUM_W'(acc_sq_i[i]);
      gyro_sum  = gyro_sum + SUM_W'(gyr_sq_i[i]);
      dev_sum   = dev_sum + DSUM_W'(dev_sq_i[i]);
    end
  end

  assign elapsed     = now_i - start_q;
  assign fall_age    = now_i - fall_since_q;
  assign move_ref_sq = {move_sq_q, {(2 * DEV_FRAC_BITS){1'b0}}};

  // threshold tests, free-fall tracking and sticky event update
  always_comb begin
    hit          = '0;
    fall_valid_d = fall_valid_q;
    fall_since_d = fall_since_q;
    if (warm_q) begin
      hit[EV_IMPACT] = total_q >= SUM_W'(impact_sq_q);
      hit[EV_MOVE]   = dev_sum >= DSUM_W'(move_ref_sq);
      hit[EV_ROTATE] = gyro_q >= SUM_W'(rotate_sq_q);
      if (total_q <= SUM_W'(ff_sq_q)) begin
        if (!fall_valid_q) begin
          fall_valid_d = 1'b1;
          fall_since_d = now_i;
        end else if (fall_age >= TIME_W'(cfg_i.freefall_hold_ms)) begin
          hit[EV_FALL] = 1'b1;
        end
      end else begin
        fall_valid_d = 1'b0;
      end
    end
    if (clear_i) begin
      events_d = '0;
      active_d = 1'b0;
    end else begin
      events_d = events_q | hit;
      active_d = active_q | (|hit);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q     <= 1'b0;
      fall_valid_q <= 1'b0;
      events_q     <= '0;
      active_q     <= 1'b0;
    end else begin
      if (step_i.load) begin
        seeded_q <= 1'b1;
      end
      if (step_i.merge) begin
        events_q <= events_d;
        active_q <= active_d;
        if (!clear_i) begin
          fall_valid_q <= fall_valid_d;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (step_i.load && !seeded_q) begin
      start_q <= now_i;
    end
    if (step_i.mul) begin
      total_q     <= total_sum;
      gyro_q      <= gyro_sum;
      warm_q      <= elapsed >= TIME_W'(cfg_i.warmup_ms);
      impact_sq_q <= cfg_i.impact_level * cfg_i.impact_level;
      move_sq_q   <= cfg_i.move_level * cfg_i.move_level;
      rotate_sq_q <= cfg_i.rotate_level * cfg_i.rotate_level;
      ff_sq_q     <= cfg_i.freefall_level * cfg_i.freefall_level;
    end
    if (step_i.merge && !clear_i) begin
      fall_since_q <= fall_since_d;
    end
  end

  assign seeded_o          = seeded_q;
  assign res_o.event_bits  = events_d;
  assign res_o.motion_flag = active_d;

endmodule

[rtl/imu_motion_event_detector_unit.sv]
// channel  | direction | beat type  | handshake
// in       | input     | imed_in_t  | in_valid_i / in_stall_o
// out      | output    | imed_out_t | out_valid_o / out_stall_i
// cfg      | input     | 16-bit reg | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// an item goes from acceptance to the output register through the
// per-axis lane sequence: seed and difference, alpha multiply, baseline add,
// deviation rounding, deviation square, then the merge stage
// the next item is taken on the cycle the result is written
// reset clears sequencer, output valid, seeded flag, free-fall and event state
// a stalled output holds its beat; the merge step waits until the slot frees
// top level: sequencer, configuration registers, three axis lanes and merge
// depends on imed_pkg, imed_lane, imed_merge
module imu_motion_event_detector_unit import imed_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  imed_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output imed_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LVL_W-1:0]     cfg_wdata_i
);

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_MUL,
    PH_UPD,
    PH_DEV,
    PH_SQ,
    PH_MERGE
  } phase_e;

  phase_e     phase_q;
  logic       busy_q;
  logic       out_valid_q;
  imed_out_t  out_q;
  imed_in_t   in_q;
  imed_cfg_t  cfg_q;

  logic       out_free;
  logic       finish;
  logic       accept;
  logic       sample;
  imed_step_t step;
  logic       seeded;
  imed_out_t  res;

  logic signed [SMP_W-1:0] accel [NUM_LANES];
  logic signed [SMP_W-1:0] gyro  [NUM_LANES];
  logic [SQ_W-1:0]         acc_sq [NUM_LANES];
  logic [SQ_W-1:0]         gyr_sq [NUM_LANES];
  logic [DSQ_W-1:0]        dev_sq [NUM_LANES];

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = busy_q && (phase_q == PH_MERGE) && out_free;
  assign in_stall_o = busy_q && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  // step enables, lanes idle on a clear item
  assign sample     = (in_q.mode == MODE_SAMPLE);
  assign step.load  = busy_q && (phase_q == PH_LOAD) && sample;
  assign step.mul   = busy_q && (phase_q == PH_MUL) && sample;
  assign step.upd   = busy_q && (phase_q == PH_UPD) && sample;
  assign step.dev   = busy_q && (phase_q == PH_DEV) && sample;
  assign step.sq    = busy_q && (phase_q == PH_SQ) && sample;
  assign step.merge = finish;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_LOAD;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        busy_q  <= 1'b1;
        phase_q <= PH_LOAD;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        case (phase_q)
          PH_LOAD:  phase_q <= PH_MUL;
          PH_MUL:   phase_q <= PH_UPD;
          PH_UPD:   phase_q <= PH_DEV;
          PH_DEV:   phase_q <= PH_SQ;
          PH_SQ:    phase_q <= PH_MERGE;
          PH_MERGE: phase_q <= PH_MERGE;
          default:  phase_q <= PH_LOAD;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.impact_level     <= 16'd12288;
      cfg_q.move_level       <= 16'd819;
      cfg_q.rotate_level     <= 16'd1965;
      cfg_q.freefall_level   <= 16'd1229;
      cfg_q.freefall_hold_ms <= 16'd200;
      cfg_q.warmup_ms        <= 16'd2000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMPACT:   cfg_q.impact_level     <= cfg_wdata_i;
        CFG_MOVE:     cfg_q.move_level       <= cfg_wdata_i;
        CFG_ROTATE:   cfg_q.rotate_level     <= cfg_wdata_i;
        CFG_FREEFALL: cfg_q.freefall_level   <= cfg_wdata_i;
        CFG_HOLD:     cfg_q.freefall_hold_ms <= cfg_wdata_i;
        CFG_WARMUP:   cfg_q.warmup_ms        <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // axis fan-out
  assign accel[0] = in_q.accel_x;
  assign accel[1] = in_q.accel_y;
  assign accel[2] = in_q.accel_z;
  assign gyro[0]  = in_q.gyro_x;
  assign gyro[1]  = in_q.gyro_y;
  assign gyro[2]  = in_q.gyro_z;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    imed_lane u_lane (
      .clk_i    (clk_i),
      .step_i   (step),
      .seeded_i (seeded),
      .accel_i  (accel[g]),
      .gyro_i   (gyro[g]),
      .acc_sq_o (acc_sq[g]),
      .gyr_sq_o (gyr_sq[g]),
      .dev_sq_o (dev_sq[g])
    );
  end

  imed_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .clear_i  (in_q.mode == MODE_CLEAR),
    .now_i    (in_q.time_ms),
    .cfg_i    (cfg_q),
    .acc_sq_i (acc_sq),
    .gyr_sq_i (gyr_sq),
    .dev_sq_i (dev_sq),
    .seeded_o (seeded),
    .res_o    (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/imed_checker.sv]
// imu motion event detector: port-level checks and their bind to the top level
// depends on imed_pkg and imu_motion_event_detector_unit_defines.svh
`include "imu_motion_event_detector_unit_defines.svh"

module imed_checker import imed_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input imed_out_t            out_data_o
);

  // a stalled result beat holds
  `IMED_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // motion flag mirrors the sticky bits
  `IMED_ASSERT(a_flag_match, out_valid_o |-> out_data_o.motion_flag == (|out_data_o.event_bits))

  // a freshly taken item keeps the input stalled
  `IMED_ASSERT_MSG(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o, "item overlap")

  // a delivered beat is not replaced unless a result was finishing
  `IMED_ASSERT(a_no_repeat, out_valid_o && !out_stall_i && in_stall_o |=> !out_valid_o)

endmodule

bind imu_motion_event_detector_unit imed_checker u_imed_checker (.*);
